// File: rtl/fbfl_pkg.sv
// Shared types and constants for the fixed block free list allocator.
// No dependencies; imported by every module of the block.
package fbfl_pkg;

  localparam int unsigned CAPACITY    = 4096;
  localparam int unsigned ADDR_W      = $clog2(CAPACITY);
  localparam int unsigned CNT_W       = 13;
  localparam int unsigned BYTES_W     = 28;
  localparam int unsigned PROD_W      = 29;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [CNT_W-1:0] CAP_CNT     = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] CHUNK_FLOOR = CNT_W'(16);
  localparam logic [15:0]      MIN_BLOCK_BYTES = 16'd8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BYTES   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_CHUNK   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LIMIT   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_ON_GRANT = 2'd3;

  // request codes
  localparam logic [1:0] FUNC_ALLOC = 2'd0;
  localparam logic [1:0] FUNC_FREE  = 2'd1;
  localparam logic [1:0] FUNC_RESET = 2'd2;
  localparam logic [1:0] FUNC_STATS = 2'd3;

  // status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_NO_BLOCK  = 2'd1;
  localparam logic [1:0] STATUS_BAD_FREE  = 2'd2;

  typedef struct packed {
    logic [15:0]      block_bytes;
    logic [CNT_W-1:0] first_chunk_blocks;
    logic [CNT_W-1:0] block_limit;
    logic             zero_on_grant;
  } cfg_t;

endpackage

// File: rtl/fbfl_cfg_regs.sv
// Configuration register bank for the allocator.
// Depends on fbfl_pkg for the register indexes and the cfg_t struct.
module fbfl_cfg_regs import fbfl_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.block_bytes        <= 16'd512;
      cfg_q.first_chunk_blocks <= CNT_W'(256);
      cfg_q.block_limit        <= CNT_W'(4096);
      cfg_q.zero_on_grant      <= 1'b1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_BLOCK_BYTES:   cfg_q.block_bytes        <= cfg_data_i;
        REG_FIRST_CHUNK:   cfg_q.first_chunk_blocks <= cfg_data_i[CNT_W-1:0];
        REG_BLOCK_LIMIT:   cfg_q.block_limit        <= cfg_data_i[CNT_W-1:0];
        REG_ZERO_ON_GRANT: cfg_q.zero_on_grant      <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/fbfl_stack_ram.sv
// Returned-handle stack storage: one write port, one read port, registered read.
// Depends on fbfl_pkg for the depth and address width.
module fbfl_stack_ram import fbfl_pkg::*; (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [ADDR_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [ADDR_W-1:0] rdata_o
);

  logic [ADDR_W-1:0] mem_q [CAPACITY];
  logic [ADDR_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/fixed_block_free_list_allocator.sv
// Fixed-size block pool allocator with a LIFO free list held in block RAM.
// Depends on fbfl_pkg, fbfl_cfg_regs and fbfl_stack_ram.
//
// Usage:
//   Requests enter on start/func_i/block_handle_i and are taken at an edge
//   where start is high and busy is low. func_i selects allocate, free,
//   pool reset or statistics read.
//   Each request gives exactly one result, shown for one cycle with done_o
//   high from the edge after the accepting edge, and taken at the edge that
//   ends that cycle. The receiver cannot stall.
//   The execute cycle (busy high) updates the counters and issues the stack RAM
//   access; the result cycle presents the result while busy is low, so the next
//   request can be taken at the edge ending the result cycle. No new request is
//   taken while one executes, since the stack RAM read is registered.
//   Configuration writes use cfg_valid_i/cfg_ready_o with cfg_index_i and
//   cfg_data_i; ready is always high. Write only while no request is in
//   flight.
//   Reset (rst_ni low) empties the pool and clears all counters and loads
//   the default configuration. The stack RAM needs no clearing: only
//   entries below the stack depth are ever read.
module fixed_block_free_list_allocator import fbfl_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            func_i,
  input  logic [ADDR_W-1:0]     block_handle_i,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic                  done_o,
  output logic [1:0]            status_o,
  output logic [ADDR_W-1:0]     granted_handle_o,
  output logic                  clear_block_o,
  output logic [CNT_W-1:0]      held_blocks_o,
  output logic [CNT_W-1:0]      idle_blocks_o,
  output logic [CNT_W-1:0]      pool_blocks_o,
  output logic [CNT_W-1:0]      peak_used_o,
  output logic [31:0]           grant_count_o,
  output logic [31:0]           release_count_o,
  output logic [31:0]           failure_count_o,
  output logic [BYTES_W-1:0]    bytes_in_use_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  cfg_t cfg;

  fbfl_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  logic [1:0]        state_q, state_d;
  logic [1:0]        func_q;
  logic [ADDR_W-1:0] handle_q;

  logic [CNT_W-1:0]   depth_q, depth_d;
  logic [CNT_W-1:0]   fresh_q, fresh_d;
  logic [ADDR_W-1:0]  base_q, base_d;
  logic [CNT_W-1:0]   grown_q, grown_d;
  logic [CNT_W-1:0]   in_use_q, in_use_d;
  logic [CNT_W-1:0]   peak_q, peak_d;
  logic [31:0]        grants_q, grants_d;
  logic [31:0]        releases_q, releases_d;
  logic [31:0]        failures_q, failures_d;
  logic [BYTES_W-1:0] bytes_q;

  // result registers filled in the execute cycle
  logic [1:0]        status_q, status_d;
  logic [ADDR_W-1:0] granted_q, granted_d;
  logic              from_stack_q, from_stack_d;
  logic              clear_q, clear_d;
  logic              grow_q, grow_d;
  logic [PROD_W-1:0] prod_q, prod_d;

  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr, ram_rdata;

  fbfl_stack_ram u_stack (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (handle_q),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  logic accept;
  assign busy   = (state_q == ST_EXEC);
  assign accept = start && !busy;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (accept) state_d = ST_EXEC;
      ST_EXEC: state_d = ST_DONE;
      ST_DONE: state_d = accept ? ST_EXEC : ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // growth sizing
  logic [CNT_W-1:0]  lim, chunk, room, n_eff;
  logic [15:0]       bsz;
  logic              can_grow;
  logic [CNT_W-1:0]  in_use_inc;
  logic [CNT_W-1:0]  hdl_ext, hdl_off;
  logic              hdl_fresh, bad_free;

  always_comb begin
    lim = (cfg.block_limit == '0 || cfg.block_limit > CAP_CNT) ? CAP_CNT : cfg.block_limit;
    if (grown_q == '0) begin
      chunk = cfg.first_chunk_blocks;
    end else begin
      chunk = (cfg.first_chunk_blocks >> 2) < CHUNK_FLOOR ? CHUNK_FLOOR
            : (cfg.first_chunk_blocks >> 2);
    end
    room     = lim - grown_q;
    n_eff    = (chunk > room) ? room : chunk;
    can_grow = (grown_q < lim) && (n_eff != '0);
    bsz      = (cfg.block_bytes < MIN_BLOCK_BYTES) ? MIN_BLOCK_BYTES : cfg.block_bytes;
    in_use_inc = in_use_q + 1'b1;
    hdl_ext  = {1'b0, handle_q};
    hdl_off  = hdl_ext - {1'b0, base_q};
    hdl_fresh = (handle_q >= base_q) && (hdl_off < fresh_q);
    bad_free = (hdl_ext >= grown_q) || (in_use_q == '0) || hdl_fresh || (depth_q >= CAP_CNT);
  end

  always_comb begin
    depth_d      = depth_q;
    fresh_d      = fresh_q;
    base_d       = base_q;
    grown_d      = grown_q;
    in_use_d     = in_use_q;
    peak_d       = peak_q;
    grants_d     = grants_q;
    releases_d   = releases_q;
    failures_d   = failures_q;
    status_d     = STATUS_OK;
    granted_d    = '0;
    from_stack_d = 1'b0;
    clear_d      = 1'b0;
    grow_d       = 1'b0;
    prod_d       = PROD_W'(n_eff) * PROD_W'(bsz);
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_waddr    = depth_q[ADDR_W-1:0];
    ram_raddr    = ADDR_W'(depth_q - 1'b1);

    if (state_q == ST_EXEC) begin
      case (func_q)
        FUNC_ALLOC: begin
          if (depth_q != '0) begin
            depth_d      = depth_q - 1'b1;
            ram_re       = 1'b1;
            from_stack_d = 1'b1;
          end else if (fresh_q != '0) begin
            fresh_d   = fresh_q - 1'b1;
            granted_d = ADDR_W'({1'b0, base_q} + fresh_q - 1'b1);
          end else if (can_grow) begin
            grow_d    = 1'b1;
            base_d    = grown_q[ADDR_W-1:0];
            fresh_d   = n_eff - 1'b1;
            grown_d   = grown_q + n_eff;
            granted_d = ADDR_W'(grown_q + n_eff - 1'b1);
          end else begin
            status_d = STATUS_NO_BLOCK;
          end
          if (status_d == STATUS_OK) begin
            in_use_d = in_use_inc;
            if (in_use_inc > peak_q) peak_d = in_use_inc;
            grants_d = (grants_q == '1) ? grants_q : grants_q + 1'b1;
            clear_d  = cfg.zero_on_grant;
          end else begin
            failures_d = (failures_q == '1) ? failures_q : failures_q + 1'b1;
          end
        end
        FUNC_FREE: begin
          if (bad_free) begin
            status_d = STATUS_BAD_FREE;
          end else begin
            ram_we     = 1'b1;
            depth_d    = depth_q + 1'b1;
            in_use_d   = in_use_q - 1'b1;
            releases_d = (releases_q == '1) ? releases_q : releases_q + 1'b1;
          end
        end
        FUNC_RESET: begin
          depth_d  = '0;
          base_d   = '0;
          fresh_d  = grown_q;
          in_use_d = '0;
        end
        FUNC_STATS: ;
        default: ;
      endcase
    end
  end

  // bytes accumulate in the result cycle from the product registered at execute
  logic [BYTES_W+1:0]  bytes_sum;
  logic [BYTES_W-1:0]  bytes_new;
  logic                bytes_upd;

  assign bytes_sum = (BYTES_W+2)'(bytes_q) + (BYTES_W+2)'(prod_q);
  assign bytes_new = (bytes_sum > (BYTES_W+2)'({BYTES_W{1'b1}})) ? '1
                   : bytes_sum[BYTES_W-1:0];
  assign bytes_upd = (state_q == ST_DONE) && grow_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      depth_q    <= '0;
      fresh_q    <= '0;
      base_q     <= '0;
      grown_q    <= '0;
      in_use_q   <= '0;
      peak_q     <= '0;
      grants_q   <= '0;
      releases_q <= '0;
      failures_q <= '0;
      bytes_q    <= '0;
      grow_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      depth_q    <= depth_d;
      fresh_q    <= fresh_d;
      base_q     <= base_d;
      grown_q    <= grown_d;
      in_use_q   <= in_use_d;
      peak_q     <= peak_d;
      grants_q   <= grants_d;
      releases_q <= releases_d;
      failures_q <= failures_d;
      if (bytes_upd) bytes_q <= bytes_new;
      if (state_q == ST_EXEC) grow_q <= grow_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q   <= func_i;
      handle_q <= block_handle_i;
    end
    if (state_q == ST_EXEC) begin
      status_q     <= status_d;
      granted_q    <= granted_d;
      from_stack_q <= from_stack_d;
      clear_q      <= clear_d;
      prod_q       <= prod_d;
    end
  end

  assign done_o           = (state_q == ST_DONE);
  assign status_o         = status_q;
  assign granted_handle_o = from_stack_q ? ram_rdata : granted_q;
  assign clear_block_o    = clear_q;
  assign held_blocks_o    = in_use_q;
  assign idle_blocks_o    = depth_q + fresh_q;
  assign pool_blocks_o    = grown_q;
  assign peak_used_o      = peak_q;
  assign grant_count_o    = grants_q;
  assign release_count_o  = releases_q;
  assign failure_count_o  = failures_q;
  assign bytes_in_use_o   = bytes_upd ? bytes_new : bytes_q;

endmodule

// File: tb/fixed_block_free_list_allocator_tb.sv
// Self-checking testbench for fixed_block_free_list_allocator: directed table, then
// random request traffic over several register settings, checked against a local predictor.
// Depends on fbfl_pkg and the allocator RTL only.
`timescale 1ns / 100ps

module fixed_block_free_list_allocator_tb;
  import fbfl_pkg::*;

  localparam int unsigned      CHUNK_DIV = 4;
  localparam longint unsigned  BYTES_CAP = (64'd1 << BYTES_W) - 1;

  typedef struct {
    logic [1:0]         status;
    logic [ADDR_W-1:0]  handle;
    logic               clear;
    logic [CNT_W-1:0]   used;
    logic [CNT_W-1:0]   idle;
    logic [CNT_W-1:0]   pool;
    logic [CNT_W-1:0]   peak;
    logic [31:0]        grants;
    logic [31:0]        releases;
    logic [31:0]        failures;
    logic [BYTES_W-1:0] bytes;
  } alloc_result_t;

  typedef struct {
    bit            is_cfg;
    bit            typed;
    logic [1:0]    code;   // request code, or register index on a register row
    logic [15:0]   value;  // handle, or write data
    alloc_result_t want;
  } stim_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  start;
  logic                  busy;
  logic [1:0]            func_i;
  logic [ADDR_W-1:0]     block_handle_i;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  done_o;
  logic [1:0]            status_o;
  logic [ADDR_W-1:0]     granted_handle_o;
  logic                  clear_block_o;
  logic [CNT_W-1:0]      held_blocks_o;
  logic [CNT_W-1:0]      idle_blocks_o;
  logic [CNT_W-1:0]      pool_blocks_o;
  logic [CNT_W-1:0]      peak_used_o;
  logic [31:0]           grant_count_o;
  logic [31:0]           release_count_o;
  logic [31:0]           failure_count_o;
  logic [BYTES_W-1:0]    bytes_in_use_o;

  fixed_block_free_list_allocator u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .func_i           (func_i),
    .block_handle_i   (block_handle_i),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .done_o           (done_o),
    .status_o         (status_o),
    .granted_handle_o (granted_handle_o),
    .clear_block_o    (clear_block_o),
    .held_blocks_o    (held_blocks_o),
    .idle_blocks_o    (idle_blocks_o),
    .pool_blocks_o    (pool_blocks_o),
    .peak_used_o      (peak_used_o),
    .grant_count_o    (grant_count_o),
    .release_count_o  (release_count_o),
    .failure_count_o  (failure_count_o),
    .bytes_in_use_o   (bytes_in_use_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // pool predictor: registers and state at their reset values
  logic [15:0]       cfg_bytes = 16'd512;
  logic [CNT_W-1:0]  cfg_first = 13'd256;
  logic [CNT_W-1:0]  cfg_limit = 13'd4096;
  logic              cfg_zero  = 1'b1;
  logic [ADDR_W-1:0] free_stack [CAPACITY];
  int unsigned       stack_depth = 0;
  int unsigned       fresh_left  = 0;
  int unsigned       fresh_lo    = 0;
  int unsigned       pool_total  = 0;
  int unsigned       in_use_n    = 0;
  int unsigned       peak_n      = 0;
  logic [31:0]       grants_n    = '0;
  logic [31:0]       releases_n  = '0;
  logic [31:0]       failures_n  = '0;
  longint unsigned   bytes_total = 0;

  alloc_result_t     pending_results [$];
  stim_row_t         directed_rows [$];
  logic [ADDR_W-1:0] handles_out [$];   // handles the predictor says are granted
  alloc_result_t     blank;

  int unsigned items_sent   = 0;
  int unsigned results_seen = 0;
  int unsigned n_granted    = 0;
  int unsigned n_refused    = 0;
  int unsigned n_bad_free   = 0;
  int unsigned mismatches   = 0;

  function automatic logic [31:0] bump(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function automatic bit grow_pool();
    int unsigned     lim;
    int unsigned     n;
    int unsigned     bsz;
    longint unsigned sum;
    lim = 32'(cfg_limit);
    if (lim == 0 || lim > CAPACITY) lim = CAPACITY;
    if (pool_total == 0) begin
      n = 32'(cfg_first);
    end else begin
      n = 32'(cfg_first) / CHUNK_DIV;
      if (n < 32'(CHUNK_FLOOR)) n = 32'(CHUNK_FLOOR);
    end
    if (pool_total >= lim) return 1'b0;
    if (n > lim - pool_total) n = lim - pool_total;
    if (n == 0) return 1'b0;
    bsz = (cfg_bytes < MIN_BLOCK_BYTES) ? 32'(MIN_BLOCK_BYTES) : 32'(cfg_bytes);
    sum = bytes_total + longint'(n) * longint'(bsz);
    bytes_total = (sum > BYTES_CAP) ? BYTES_CAP : sum;
    fresh_lo   = pool_total;
    fresh_left = n;
    pool_total += n;
    return 1'b1;
  endfunction

  function automatic alloc_result_t apply_request(input logic [1:0] fn,
                                                  input logic [ADDR_W-1:0] h);
    alloc_result_t r;
    bit            ok;
    bit            in_fresh;
    r = blank;
    case (fn)
      FUNC_ALLOC: begin
        ok = 1'b1;
        if (stack_depth > 0) begin
          stack_depth--;
          r.handle = free_stack[ADDR_W'(stack_depth)];
        end else begin
          if (fresh_left == 0) ok = grow_pool();
          if (ok) begin
            fresh_left--;
            r.handle = ADDR_W'(fresh_lo + fresh_left);
          end
        end
        if (ok) begin
          in_use_n++;
          if (in_use_n > peak_n) peak_n = in_use_n;
          grants_n = bump(grants_n);
          r.clear  = cfg_zero;
        end else begin
          r.status   = STATUS_NO_BLOCK;
          failures_n = bump(failures_n);
        end
      end
      FUNC_FREE: begin
        // handles not yet handed out from the newest chunk cannot be freed
        in_fresh = (32'(h) >= fresh_lo) && (32'(h) - fresh_lo < fresh_left);
        if (32'(h) >= pool_total || in_use_n == 0 || in_fresh || stack_depth >= CAPACITY) begin
          r.status = STATUS_BAD_FREE;
        end else begin
          free_stack[ADDR_W'(stack_depth)] = h;
          stack_depth++;
          in_use_n--;
          releases_n = bump(releases_n);
        end
      end
      FUNC_RESET: begin
        stack_depth = 0;
        fresh_lo    = 0;
        fresh_left  = pool_total;
        in_use_n    = 0;
      end
      default: ;
    endcase
    r.used     = CNT_W'(in_use_n);
    r.idle     = CNT_W'(stack_depth + fresh_left);
    r.pool     = CNT_W'(pool_total);
    r.peak     = CNT_W'(peak_n);
    r.grants   = grants_n;
    r.releases = releases_n;
    r.failures = failures_n;
    r.bytes    = bytes_total[BYTES_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got_v,
                             input logic [63:0] want_v);
    if (got_v !== want_v)
      report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                results_seen, name, got_v, want_v));
  endtask

  task automatic add_row(input bit is_cfg, input bit typed, input logic [1:0] code,
                         input logic [15:0] value, input alloc_result_t want);
    stim_row_t row;
    row.is_cfg = is_cfg;
    row.typed  = typed;
    row.code   = code;
    row.value  = value;
    row.want   = want;
    directed_rows.push_back(row);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // leaves valid high so back-to-back writes need no drop; callers lower it
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] d);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    case (idx)
      REG_BLOCK_BYTES:   cfg_bytes = d;
      REG_FIRST_CHUNK:   cfg_first = d[CNT_W-1:0];
      REG_BLOCK_LIMIT:   cfg_limit = d[CNT_W-1:0];
      REG_ZERO_ON_GRANT: cfg_zero  = d[0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [15:0] bb, input logic [15:0] fc,
                            input logic [15:0] bl, input logic [15:0] zg);
    wait_drained();
    write_reg(REG_BLOCK_BYTES, bb);
    write_reg(REG_FIRST_CHUNK, fc);
    write_reg(REG_BLOCK_LIMIT, bl);
    write_reg(REG_ZERO_ON_GRANT, zg);
    cfg_valid_i <= 1'b0;
  endtask

  // start stays high after the beat; the next call either keeps it or drops it
  task automatic send_req(input logic [1:0] fn, input logic [ADDR_W-1:0] h,
                          input bit typed, input alloc_result_t typed_want);
    alloc_result_t want;
    while ((items_sent < 700 || items_sent >= 1000) && $urandom_range(0, 99) < 17) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start          <= 1'b1;
    func_i         <= fn;
    block_handle_i <= h;
    do @(posedge clk_i); while (busy !== 1'b0);
    items_sent++;
    want = apply_request(fn, h);
    if (fn == FUNC_ALLOC && want.status == STATUS_OK) begin
      handles_out.push_back(want.handle);
      n_granted++;
    end else if (fn == FUNC_FREE && want.status == STATUS_OK) begin
      for (int k = 0; k < handles_out.size(); k++) begin
        if (handles_out[k] == h) begin
          handles_out.delete(k);
          break;
        end
      end
    end else if (fn == FUNC_RESET) begin
      handles_out.delete();
    end
    pending_results.push_back(typed ? typed_want : want);
  endtask

  // random allocations and frees, frees mostly of handles actually held, plus stray handles, resets and reads
  task automatic run_phase(input int unsigned n_items, input int unsigned alloc_pm,
                           input int unsigned reset_pm);
    int unsigned       r;
    logic [1:0]        fn;
    logic [ADDR_W-1:0] h;
    for (int unsigned i = 0; i < n_items; i++) begin
      r = $urandom_range(0, 999);
      h = ADDR_W'($urandom_range(0, CAPACITY - 1));
      if (r < reset_pm) begin
        fn = FUNC_RESET;
      end else if (r < reset_pm + 60) begin
        fn = FUNC_STATS;
      end else if (r < reset_pm + 60 + alloc_pm) begin
        fn = FUNC_ALLOC;
      end else begin
        fn = FUNC_FREE;
        if (handles_out.size() != 0 && $urandom_range(0, 9) < 8)
          h = handles_out[$urandom_range(0, handles_out.size() - 1)];
        else if (pool_total != 0 && $urandom_range(0, 1) == 1)
          h = ADDR_W'($urandom_range(0, pool_total - 1));
      end
      send_req(fn, h, 1'b0, blank);
    end
  endtask

  always @(posedge clk_i) begin : result_check
    alloc_result_t got;
    alloc_result_t want;
    if (rst_ni === 1'b1 && done_o === 1'b1) begin
      got.status   = status_o;
      got.handle   = granted_handle_o;
      got.clear    = clear_block_o;
      got.used     = held_blocks_o;
      got.idle     = idle_blocks_o;
      got.pool     = pool_blocks_o;
      got.peak     = peak_used_o;
      got.grants   = grant_count_o;
      got.releases = release_count_o;
      got.failures = failure_count_o;
      got.bytes    = bytes_in_use_o;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result beat with nothing outstanding, status %0d",
                                  got.status));
      end else begin
        want = pending_results.pop_front();
        check_field("status", 64'(got.status), 64'(want.status));
        check_field("granted_handle", 64'(got.handle), 64'(want.handle));
        check_field("clear_block", 64'(got.clear), 64'(want.clear));
        check_field("held_blocks", 64'(got.used), 64'(want.used));
        check_field("idle_blocks", 64'(got.idle), 64'(want.idle));
        check_field("pool_blocks", 64'(got.pool), 64'(want.pool));
        check_field("peak_used", 64'(got.peak), 64'(want.peak));
        check_field("grant_count", 64'(got.grants), 64'(want.grants));
        check_field("release_count", 64'(got.releases), 64'(want.releases));
        check_field("failure_count", 64'(got.failures), 64'(want.failures));
        check_field("bytes_in_use", 64'(got.bytes), 64'(want.bytes));
        case (want.status)
          STATUS_OK:       ;
          STATUS_NO_BLOCK: n_refused++;
          default:         n_bad_free++;
        endcase
      end
      results_seen++;
    end
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    alloc_result_t w;
    stim_row_t     row;
    start          = 1'b0;
    func_i         = FUNC_STATS;
    block_handle_i = '0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = REG_BLOCK_BYTES;
    cfg_data_i     = '0;
    rst_ni         = 1'b0;
    blank          = '{default: '0};

    // directed part: fresh pool, failed first chunk, small pool, LIFO reuse, double free
    w = blank;
    add_row(1'b0, 1'b1, FUNC_STATS, 16'd0, w);
    w.status = STATUS_BAD_FREE;
    add_row(1'b0, 1'b1, FUNC_FREE, 16'd0, w);
    add_row(1'b1, 1'b0, REG_FIRST_CHUNK, 16'd0, blank);
    w = blank;
    w.status   = STATUS_NO_BLOCK;
    w.failures = 32'd1;
    add_row(1'b0, 1'b1, FUNC_ALLOC, 16'd0, w);
    add_row(1'b1, 1'b0, REG_FIRST_CHUNK, 16'd8, blank);
    add_row(1'b1, 1'b0, REG_BLOCK_BYTES, 16'd3, blank);
    // block size below the minimum counts as 8 bytes
    w = '{STATUS_OK, 12'd7, 1'b1, 13'd1, 13'd7, 13'd8, 13'd1, 32'd1, 32'd0, 32'd1, 28'd64};
    add_row(1'b0, 1'b1, FUNC_ALLOC, 16'hFFF, w);
    w = '{STATUS_BAD_FREE, 12'd0, 1'b0, 13'd1, 13'd7, 13'd8, 13'd1, 32'd1, 32'd0, 32'd1,
          28'd64};
    add_row(1'b0, 1'b1, FUNC_FREE, 16'hFFF, w);
    add_row(1'b0, 1'b0, FUNC_FREE, 16'd0, blank);   // not yet granted
    add_row(1'b0, 1'b0, FUNC_FREE, 16'd7, blank);
    add_row(1'b0, 1'b0, FUNC_FREE, 16'd7, blank);   // nothing in use
    add_row(1'b0, 1'b0, FUNC_ALLOC, 16'd0, blank);
    add_row(1'b0, 1'b0, FUNC_ALLOC, 16'd0, blank);
    add_row(1'b0, 1'b0, FUNC_FREE, 16'd6, blank);
    add_row(1'b0, 1'b0, FUNC_FREE, 16'd7, blank);
    add_row(1'b0, 1'b0, FUNC_ALLOC, 16'd0, blank);
    add_row(1'b0, 1'b0, FUNC_ALLOC, 16'd0, blank);
    add_row(1'b1, 1'b0, REG_ZERO_ON_GRANT, 16'd0, blank);
    add_row(1'b0, 1'b0, FUNC_ALLOC, 16'd0, blank);
    add_row(1'b0, 1'b0, FUNC_FREE, 16'd5, blank);
    add_row(1'b0, 1'b0, FUNC_FREE, 16'd5, blank);   // stacked twice, still accepted
    add_row(1'b0, 1'b0, FUNC_ALLOC, 16'd0, blank);
    add_row(1'b0, 1'b0, FUNC_ALLOC, 16'd0, blank);
    add_row(1'b0, 1'b0, FUNC_RESET, 16'hFFF, blank);
    add_row(1'b0, 1'b0, FUNC_STATS, 16'hFFF, blank);
    add_row(1'b0, 1'b0, FUNC_ALLOC, 16'd0, blank);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int unsigned i = 0; i < directed_rows.size(); i++) begin
      row = directed_rows[i];
      if (row.is_cfg) begin
        wait_drained();
        write_reg(row.code, row.value);
        if (i + 1 == directed_rows.size() || !directed_rows[i + 1].is_cfg)
          cfg_valid_i <= 1'b0;
      end else begin
        send_req(row.code, row.value[ADDR_W-1:0], row.typed, row.want);
      end
    end

    // growth clipped at a small limit
    set_config(16'hFFFF, 16'd1, 16'd100, 16'd0);
    run_phase(346, 700, 0);
    // limit below the pool size: no further growth
    set_config(16'd8, 16'd4096, 16'd90, 16'd1);
    run_phase(346, 600, 3);
    // zero limit means full capacity, chunks of the floor size
    set_config(16'd0, 16'd64, 16'd0, 16'd0);
    run_phase(346, 650, 5);
    // out-of-range limit and widest register values
    set_config(16'd1000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_phase(346, 500, 10);
    set_config(16'd512, 16'd256, 16'd4096, 16'd1);
    run_phase(346, 450, 40);

    wait_drained();
    repeat (4) @(posedge clk_i);

    $display("%0d requests, %0d results checked: %0d grants, %0d refused allocations,",
             items_sent, results_seen, n_granted, n_refused);
    $display("%0d refused frees; pool grew to %0d blocks, peak use %0d, %0d mismatches",
             n_bad_free, pool_total, peak_n, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
